// ----- sv/ppk_pkg.sv -----
// ----------------------------------------------------------------------------
// ppk_pkg
// Shared types and constants for the 12bpp palette pixel packer.
// ----------------------------------------------------------------------------
`default_nettype none

package ppk_pkg;

	// palette
	localparam int PALETTE_DEPTH = 256;
	localparam int PAL_AW        = $clog2(PALETTE_DEPTH);
	localparam int COLOR_W       = 12;
	localparam int BYTE_W        = 8;

	// front-to-back job queue
	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// input item kinds
	typedef logic [1:0] ppk_kind_t;
	localparam ppk_kind_t KIND_PALETTE = 2'd0;
	localparam ppk_kind_t KIND_START   = 2'd1;
	localparam ppk_kind_t KIND_PIXEL   = 2'd2;
	localparam ppk_kind_t KIND_END     = 2'd3;

	// configuration register indexes
	typedef logic [0:0] ppk_cfg_idx_t;
	localparam ppk_cfg_idx_t CFG_WRITE_CMD = 1'd0;
	localparam ppk_cfg_idx_t CFG_END_CMD   = 1'd1;

	// reset values of the command registers
	localparam logic [BYTE_W-1:0] MEMWR_CMD_RST = 8'd44;
	localparam logic [BYTE_W-1:0] NOP_CMD_RST   = 8'd0;

	// byte position within a packed pixel pair
	typedef logic [1:0] ppk_bpos_t;
	localparam ppk_bpos_t BPOS_HI  = 2'd0;
	localparam ppk_bpos_t BPOS_MID = 2'd1;
	localparam ppk_bpos_t BPOS_LO  = 2'd2;

	// queued job: a command byte (in color_b low byte) or a pixel pair
	typedef struct packed {
		logic               is_pair;
		logic [COLOR_W-1:0] color_a;
		logic [COLOR_W-1:0] color_b;
	} ppk_job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} ppk_q_stat_t;

	typedef struct packed {
		logic      busy;
		ppk_bpos_t bpos;
	} ppk_back_stat_t;

endpackage

`default_nettype wire

// ----- sv/ppk_ram.sv -----
// ----------------------------------------------------------------------------
// ppk_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ppk_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- sv/ppk_front.sv -----
// ----------------------------------------------------------------------------
// ppk_front
// Accepts items, does palette writes and lookups, pairs pixels and issues
// jobs into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module ppk_front (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire ppk_pkg::ppk_kind_t            in_kind,
	input  wire logic [7:0]                    in_palette_index,
	input  wire logic [ppk_pkg::COLOR_W-1:0]   in_palette_color,
	input  wire logic [7:0]                    in_pixel_index,
	input  wire logic [ppk_pkg::BYTE_W-1:0]    write_cmd,
	input  wire logic [ppk_pkg::BYTE_W-1:0]    end_cmd,
	output logic                               q_push,
	output ppk_pkg::ppk_job_t                  q_job,
	input  wire ppk_pkg::ppk_q_stat_t          q_stat
);

	import ppk_pkg::*;

	logic               accept;
	logic               pal_we;
	logic               pix_re;
	logic [COLOR_W-1:0] rdata;
	logic               valid_s1;
	ppk_kind_t          kind_s1;
	logic               oor_s1;
	logic               odd_q;
	logic [COLOR_W-1:0] held_q;
	logic [COLOR_W-1:0] pix_color;
	logic               push;
	logic               go;

	assign accept = in_valid && in_ready;
	assign pal_we = accept && (in_kind == KIND_PALETTE)
		&& ({1'b0, in_palette_index} < 9'(PALETTE_DEPTH));
	assign pix_re = accept && (in_kind == KIND_PIXEL);

	ppk_ram #(
		.WIDTH(COLOR_W),
		.DEPTH(PALETTE_DEPTH)
	) u_palette (
		.clk  (clk),
		.we   (pal_we),
		.waddr(in_palette_index[PAL_AW-1:0]),
		.wdata(in_palette_color),
		.re   (pix_re),
		.raddr(in_pixel_index[PAL_AW-1:0]),
		.rdata(rdata)
	);

	// index past the palette reads as black
	assign pix_color = oor_s1 ? '0 : rdata;

	always_comb begin
		push  = 1'b0;
		q_job = '0;
		unique case (kind_s1)
			KIND_START: begin
				push          = 1'b1;
				q_job.color_b = {{(COLOR_W-BYTE_W){1'b0}}, write_cmd};
			end
			KIND_END: begin
				push          = 1'b1;
				q_job.color_b = {{(COLOR_W-BYTE_W){1'b0}}, end_cmd};
			end
			KIND_PIXEL: begin
				push          = odd_q;
				q_job.is_pair = 1'b1;
				q_job.color_a = held_q;
				q_job.color_b = pix_color;
			end
			KIND_PALETTE: begin
			end
		endcase
	end

	assign go       = valid_s1 && (!push || !q_stat.full);
	assign q_push   = valid_s1 && push && !q_stat.full;
	assign in_ready = !valid_s1 || go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			odd_q    <= 1'b0;
			held_q   <= '0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (go) begin
				unique case (kind_s1)
					KIND_START, KIND_END: begin
						odd_q <= 1'b0;
					end
					KIND_PIXEL: begin
						if (!odd_q) begin
							held_q <= pix_color;
							odd_q  <= 1'b1;
						end else begin
							odd_q <= 1'b0;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_s1 <= KIND_PALETTE;
			oor_s1  <= 1'b0;
		end else if (accept) begin
			kind_s1 <= in_kind;
			oor_s1  <= !({1'b0, in_pixel_index} < 9'(PALETTE_DEPTH));
		end
	end

endmodule

`default_nettype wire

// ----- sv/ppk_queue.sv -----
// ----------------------------------------------------------------------------
// ppk_queue
// Short job FIFO between the front and the byte emitter.
// ----------------------------------------------------------------------------
`default_nettype none

module ppk_queue (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	input  wire ppk_pkg::ppk_job_t    push_job,
	input  wire logic                 pop,
	output ppk_pkg::ppk_job_t         head_job,
	output ppk_pkg::ppk_q_stat_t      stat
);

	import ppk_pkg::*;

	ppk_job_t           mem_q [QDEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;
	logic               do_push;
	logic               do_pop;

	assign stat.full  = (count_q == QCNT_W'(QDEPTH));
	assign stat.empty = (count_q == '0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign head_job   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

`default_nettype wire

// ----- sv/ppk_back.sv -----
// ----------------------------------------------------------------------------
// ppk_back
// Turns queued jobs into output bytes, one per cycle while a job is queued
// and out_ready is high, through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ppk_back (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire ppk_pkg::ppk_job_t           job,
	input  wire ppk_pkg::ppk_q_stat_t        q_stat,
	output logic                             pop,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [ppk_pkg::BYTE_W-1:0]       out_byte,
	output logic                             out_is_data,
	output logic                             out_last,
	output ppk_pkg::ppk_back_stat_t          stat
);

	import ppk_pkg::*;

	logic              out_valid_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic              out_is_data_q;
	logic              out_last_q;
	ppk_bpos_t         bpos_q;
	logic              load;
	logic [BYTE_W-1:0] nxt_byte;
	logic              nxt_last;

	assign load = (!out_valid_q || out_ready) && !q_stat.empty;

	always_comb begin
		nxt_byte = job.color_b[BYTE_W-1:0];
		nxt_last = 1'b1;
		if (job.is_pair) begin
			unique case (bpos_q)
				BPOS_HI: begin
					nxt_byte = job.color_a[11:4];
					nxt_last = 1'b0;
				end
				BPOS_MID: begin
					nxt_byte = {job.color_a[3:0], job.color_b[11:8]};
					nxt_last = 1'b0;
				end
				default: begin
					nxt_byte = job.color_b[7:0];
					nxt_last = 1'b1;
				end
			endcase
		end
	end

	assign pop = load && nxt_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			bpos_q      <= BPOS_HI;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				bpos_q      <= nxt_last ? BPOS_HI : bpos_q + 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q    <= nxt_byte;
			out_is_data_q <= job.is_pair;
			out_last_q    <= nxt_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_byte    = out_byte_q;
	assign out_is_data = out_is_data_q;
	assign out_last    = out_last_q;
	assign stat.busy   = (bpos_q != BPOS_HI);
	assign stat.bpos   = bpos_q;

endmodule

`default_nettype wire

// ----- sv/palette_pixel_packer_12bpp_top.sv -----
// ----------------------------------------------------------------------------
// palette_pixel_packer_12bpp_top
// Palette lookup and 12bpp pixel packer feeding a display byte stream.
// ----------------------------------------------------------------------------
// An item's first byte passes the front stage register, the job queue and the
// output register. One item in per cycle, unless a job meets a full queue;
// one byte out per cycle while the sink is ready. A pixel pair is 3 bytes.
// A 2-entry job queue lets the input side run ahead of the byte emitter.
// Reset (arst_n low, async) clears control state and loads the command
// registers; palette contents are not cleared.
`default_nettype none

module palette_pixel_packer_12bpp_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input items
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [31:0] s_axis_tdata,  // [7:0] palette_index, [19:8] palette_color,
	                                        // [27:20] pixel_index, [31:28] zero
	input  wire logic [1:0]  s_axis_tuser,  // [1:0] kind
	// output bytes
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [7:0]       m_axis_tdata,  // [7:0] out_byte
	output logic [0:0]       m_axis_tuser,  // [0] is_data
	output logic             m_axis_tlast,
	// configuration writes
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [0:0]  cfg_index,
	input  wire logic [7:0]  cfg_data
);

	import ppk_pkg::*;

	logic [BYTE_W-1:0] write_cmd_q;
	logic [BYTE_W-1:0] end_cmd_q;
	logic              q_push;
	ppk_job_t          q_job;
	ppk_q_stat_t       q_stat;
	logic              q_pop;
	ppk_job_t          head_job;
	ppk_back_stat_t    back_stat;
	logic              out_is_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_cmd_q <= MEMWR_CMD_RST;
			end_cmd_q   <= NOP_CMD_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_WRITE_CMD: write_cmd_q <= cfg_data;
				CFG_END_CMD:   end_cmd_q   <= cfg_data;
			endcase
		end
	end

	ppk_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (s_axis_tvalid),
		.in_ready        (s_axis_tready),
		.in_kind         (s_axis_tuser),
		.in_palette_index(s_axis_tdata[7:0]),
		.in_palette_color(s_axis_tdata[19:8]),
		.in_pixel_index  (s_axis_tdata[27:20]),
		.write_cmd       (write_cmd_q),
		.end_cmd         (end_cmd_q),
		.q_push          (q_push),
		.q_job           (q_job),
		.q_stat          (q_stat)
	);

	ppk_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.push_job(q_job),
		.pop     (q_pop),
		.head_job(head_job),
		.stat    (q_stat)
	);

	ppk_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.job        (head_job),
		.q_stat     (q_stat),
		.pop        (q_pop),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_byte   (m_axis_tdata),
		.out_is_data(out_is_data),
		.out_last   (m_axis_tlast),
		.stat       (back_stat)
	);

	assign m_axis_tuser = out_is_data;

	// command bytes are always the single, final byte of their item
	a_cmd_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tlast)
		else $error("command byte without tlast");

	// mid-pair, the pair job stays at the queue head
	a_pair_held: assert property (@(posedge clk) disable iff (!arst_n)
		back_stat.busy |-> !q_stat.empty)
		else $error("pair in progress but queue empty");

	a_bpos_range: assert property (@(posedge clk) disable iff (!arst_n)
		back_stat.bpos != 2'd3)
		else $error("byte position out of range");

	// a non-final data byte is followed at once by the next byte of the pair
	a_pair_cont: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && m_axis_tuser[0] && !m_axis_tlast
		|=> m_axis_tvalid && m_axis_tuser[0])
		else $error("pixel pair bytes interrupted");

endmodule

`default_nettype wire

// ----- test/palette_pixel_packer_12bpp_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// palette_pixel_packer_12bpp_top_tb
// Self-checking bench for the palette lookup and 12bpp pixel packer.
// A short table of directed items runs first. It covers the field extremes,
// every item kind, unpaired pixels dropped at frame start and frame end, and
// pixels outside a frame. Random frames follow under several command-code
// settings. Every output byte is compared in order against fixed table bytes
// or a cycle-free copy of the packer. Both stream sides throttle at random.
// ----------------------------------------------------------------------------

module palette_pixel_packer_12bpp_top_tb;
	import ppk_pkg::*;

	localparam int GAP_MAX      = 14;
	localparam int DRAIN_CYCLES = 12;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int NDIR         = 20;
	localparam int PHASE_ITEMS  = 65;

	typedef struct packed {
		ppk_kind_t          kind;
		logic [PAL_AW-1:0]  pal_idx;
		logic [COLOR_W-1:0] pal_color;
		logic [PAL_AW-1:0]  pix_idx;
	} item_t;

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic              is_data;
		logic              last;
	} disp_byte_t;

	// fixed_bytes: first byte in [23:16]; a command row uses only that byte
	typedef struct packed {
		ppk_kind_t          kind;
		logic [PAL_AW-1:0]  pal_idx;
		logic [COLOR_W-1:0] pal_color;
		logic [PAL_AW-1:0]  pix_idx;
		logic               fixed;
		logic [23:0]        fixed_bytes;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = '0;
	logic [1:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [7:0]  m_axis_tdata;
	logic [0:0]  m_axis_tuser;
	logic        m_axis_tlast;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [0:0]  cfg_index = '0;
	logic [7:0]  cfg_data = '0;

	palette_pixel_packer_12bpp_top uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// packer state as seen from outside
	logic [COLOR_W-1:0] pal_mem [PALETTE_DEPTH];
	logic [COLOR_W-1:0] held_color;
	logic               odd_phase;
	logic [BYTE_W-1:0]  cmd_start;
	logic [BYTE_W-1:0]  cmd_end;

	// entries written so far; pixels only ever point at these
	bit pal_written [PALETTE_DEPTH];
	int written_list [$];

	disp_byte_t pending_bytes [$];
	disp_byte_t rx_exp;
	int         err_count;
	int         cycle_count;
	int         items_sent;
	int         rx_gap;
	int         rx_wait;
	bit         rx_calm;
	bit         tx_calm;

	dir_row_t dir_table [NDIR] = '{
		'{KIND_START,   8'h00, 12'h000, 8'h00, 1'b1, 24'h2C0000},
		'{KIND_PALETTE, 8'h00, 12'h000, 8'h00, 1'b0, 24'h0},
		'{KIND_PALETTE, 8'hFF, 12'hFFF, 8'h00, 1'b0, 24'h0},
		'{KIND_PALETTE, 8'hA5, 12'h5A3, 8'h00, 1'b0, 24'h0},
		'{KIND_PALETTE, 8'h5A, 12'hA5C, 8'h00, 1'b0, 24'h0},
		'{KIND_PIXEL,   8'h00, 12'h000, 8'h00, 1'b0, 24'h0},
		'{KIND_PIXEL,   8'h00, 12'h000, 8'hFF, 1'b1, 24'h000FFF},
		'{KIND_PIXEL,   8'h00, 12'h000, 8'hFF, 1'b0, 24'h0},
		'{KIND_PIXEL,   8'h00, 12'h000, 8'h00, 1'b1, 24'hFFF000},
		'{KIND_PIXEL,   8'h00, 12'h000, 8'hA5, 1'b0, 24'h0},
		// held pixel dropped by frame end
		'{KIND_END,     8'h00, 12'h000, 8'h00, 1'b1, 24'h000000},
		// pair outside any frame
		'{KIND_PIXEL,   8'h00, 12'h000, 8'h5A, 1'b0, 24'h0},
		'{KIND_PIXEL,   8'h00, 12'h000, 8'hA5, 1'b0, 24'h0},
		'{KIND_START,   8'h00, 12'h000, 8'h00, 1'b1, 24'h2C0000},
		// held pixel dropped by frame start
		'{KIND_PIXEL,   8'h00, 12'h000, 8'hA5, 1'b0, 24'h0},
		'{KIND_START,   8'h00, 12'h000, 8'h00, 1'b1, 24'h2C0000},
		'{KIND_PALETTE, 8'h00, 12'h123, 8'h00, 1'b0, 24'h0},
		'{KIND_PIXEL,   8'h00, 12'h000, 8'h00, 1'b0, 24'h0},
		'{KIND_PIXEL,   8'h00, 12'h000, 8'h5A, 1'b0, 24'h0},
		'{KIND_END,     8'h00, 12'h000, 8'h00, 1'b1, 24'h000000}
	};

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[palette_pixel_packer_12bpp_top] ERROR");
			$finish;
		end
	end

	task automatic note_error(input string msg);
		err_count++;
		if (err_count <= 10)
			$display("%s", msg);
	endtask

	task automatic pack_predict(input item_t it, input bit queue_it);
		logic [COLOR_W-1:0] color;
		case (it.kind)
			KIND_PALETTE: begin
				if (int'(it.pal_idx) < PALETTE_DEPTH) begin
					pal_mem[it.pal_idx] = it.pal_color;
					if (!pal_written[it.pal_idx]) begin
						pal_written[it.pal_idx] = 1'b1;
						written_list.push_back(int'(it.pal_idx));
					end
				end
			end
			KIND_START: begin
				odd_phase = 1'b0;
				if (queue_it)
					pending_bytes.push_back(disp_byte_t'{cmd_start, 1'b0, 1'b1});
			end
			KIND_END: begin
				odd_phase = 1'b0;
				if (queue_it)
					pending_bytes.push_back(disp_byte_t'{cmd_end, 1'b0, 1'b1});
			end
			default: begin
				color = (int'(it.pix_idx) < PALETTE_DEPTH) ? pal_mem[it.pix_idx] : '0;
				if (!odd_phase) begin
					held_color = color;
					odd_phase  = 1'b1;
				end else begin
					odd_phase = 1'b0;
					if (queue_it) begin
						pending_bytes.push_back(disp_byte_t'{held_color[11:4], 1'b1, 1'b0});
						pending_bytes.push_back(
							disp_byte_t'{{held_color[3:0], color[11:8]}, 1'b1, 1'b0});
						pending_bytes.push_back(disp_byte_t'{color[7:0], 1'b1, 1'b1});
					end
				end
			end
		endcase
	endtask

	task automatic send_item(input item_t it, input bit fixed, input logic [23:0] fixed_bytes);
		int gap;
		gap = tx_calm ? 0 : $urandom_range(0, GAP_MAX);
		if ($urandom_range(0, 15) == 0)
			tx_calm = !tx_calm;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {4'b0, it.pix_idx, it.pal_color, it.pal_idx};
		s_axis_tuser  <= it.kind;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		items_sent++;
		pack_predict(it, !fixed);
		if (fixed) begin
			if (it.kind == KIND_PIXEL) begin
				pending_bytes.push_back(disp_byte_t'{fixed_bytes[23:16], 1'b1, 1'b0});
				pending_bytes.push_back(disp_byte_t'{fixed_bytes[15:8], 1'b1, 1'b0});
				pending_bytes.push_back(disp_byte_t'{fixed_bytes[7:0], 1'b1, 1'b1});
			end else begin
				pending_bytes.push_back(disp_byte_t'{fixed_bytes[23:16], 1'b0, 1'b1});
			end
		end
	endtask

	task automatic wait_drained(input int extra);
		s_axis_tvalid <= 1'b0;
		while (pending_bytes.size() != 0) @(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	task automatic load_commands(input logic [7:0] start_code, input logic [7:0] end_code);
		ppk_cfg_idx_t idx;
		logic [7:0]   val;
		for (int r = 0; r < 2; r++) begin
			idx = (r == 0) ? CFG_WRITE_CMD : CFG_END_CMD;
			val = (r == 0) ? start_code : end_code;
			cfg_valid <= 1'b1;
			cfg_index <= idx;
			cfg_data  <= val;
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
			if (idx == CFG_WRITE_CMD)
				cmd_start = val;
			else
				cmd_end = val;
		end
		cfg_valid <= 1'b0;
	endtask

	function automatic item_t make_item(input ppk_kind_t kind);
		item_t it;
		it.kind      = kind;
		it.pal_idx   = PAL_AW'($urandom_range(0, PALETTE_DEPTH - 1));
		it.pal_color = COLOR_W'($urandom());
		if ($urandom_range(0, 7) == 0)
			it.pal_color = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
		it.pix_idx = PAL_AW'($urandom());
		if (kind == KIND_PIXEL)
			it.pix_idx = PAL_AW'(written_list[$urandom_range(0, written_list.size() - 1)]);
		return it;
	endfunction

	task automatic play_frame();
		int npix;
		npix = 2 * $urandom_range(1, 6);
		// odd count leaves an unpaired pixel at the end of the frame
		if ($urandom_range(0, 5) == 0)
			npix++;
		send_item(make_item(KIND_START), 1'b0, '0);
		for (int p = 0; p < npix; p++) begin
			if ($urandom_range(0, 7) == 0)
				send_item(make_item(KIND_PALETTE), 1'b0, '0);
			send_item(make_item(KIND_PIXEL), 1'b0, '0);
		end
		if ($urandom_range(0, 7) != 0)
			send_item(make_item(KIND_END), 1'b0, '0);
	endtask

	task automatic run_phase();
		int first;
		int sel;
		first = items_sent;
		while (items_sent - first < PHASE_ITEMS) begin
			sel = $urandom_range(0, 9);
			if (sel < 7) begin
				play_frame();
			end else if (sel == 7) begin
				repeat ($urandom_range(1, 4)) send_item(make_item(KIND_PALETTE), 1'b0, '0);
			end else if (sel == 8) begin
				send_item(make_item(ppk_kind_t'($urandom_range(0, 3))), 1'b0, '0);
			end else begin
				repeat ($urandom_range(1, 3)) send_item(make_item(KIND_PIXEL), 1'b0, '0);
			end
			// now and then, hold off until the output side has caught up
			if ($urandom_range(0, 29) == 0)
				wait_drained(0);
		end
	endtask

	// output side: check each transfer, then stall at random
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (pending_bytes.size() == 0) begin
					note_error($sformatf("cycle %0d: unexpected byte %h is_data %b last %b",
						cycle_count, m_axis_tdata, m_axis_tuser[0], m_axis_tlast));
				end else begin
					rx_exp = pending_bytes.pop_front();
					if (m_axis_tdata !== rx_exp.data || m_axis_tuser[0] !== rx_exp.is_data ||
					    m_axis_tlast !== rx_exp.last)
						note_error($sformatf(
							"cycle %0d: expected byte %h is_data %b last %b, got %h %b %b",
							cycle_count, rx_exp.data, rx_exp.is_data, rx_exp.last,
							m_axis_tdata, m_axis_tuser[0], m_axis_tlast));
				end
				rx_gap = rx_calm ? 0 : $urandom_range(0, GAP_MAX);
				if ($urandom_range(0, 15) == 0)
					rx_calm = !rx_calm;
				if (rx_gap == 0) begin
					m_axis_tready <= 1'b1;
				end else begin
					m_axis_tready <= 1'b0;
					rx_wait       <= rx_gap - 1;
				end
			end else if (rx_wait != 0) begin
				m_axis_tready <= 1'b0;
				rx_wait       <= rx_wait - 1;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	initial begin
		dir_row_t row;
		item_t    it;
		err_count   = 0;
		cycle_count = 0;
		items_sent  = 0;
		rx_wait     = 0;
		rx_calm     = 1'b0;
		tx_calm     = 1'b0;
		held_color  = '0;
		odd_phase   = 1'b0;
		cmd_start   = MEMWR_CMD_RST;
		cmd_end     = NOP_CMD_RST;
		for (int i = 0; i < PALETTE_DEPTH; i++) begin
			pal_mem[i]     = '0;
			pal_written[i] = 1'b0;
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int d = 0; d < NDIR; d++) begin
			row          = dir_table[d];
			it.kind      = row.kind;
			it.pal_idx   = row.pal_idx;
			it.pal_color = row.pal_color;
			it.pix_idx   = row.pix_idx;
			send_item(it, row.fixed, row.fixed_bytes);
		end
		wait_drained(DRAIN_CYCLES);

		load_commands(8'hFF, 8'h00);
		run_phase();
		wait_drained(DRAIN_CYCLES);

		load_commands(8'h00, 8'hFF);
		run_phase();
		wait_drained(DRAIN_CYCLES);

		repeat (2) begin
			load_commands(8'($urandom()), 8'($urandom()));
			run_phase();
			wait_drained(DRAIN_CYCLES);
		end

		if (err_count == 0 && pending_bytes.size() == 0)
			$display("[palette_pixel_packer_12bpp_top] OK");
		else
			$display("[palette_pixel_packer_12bpp_top] ERROR");
		$finish;
	end

endmodule

// ----- files.f -----
sv/ppk_pkg.sv
sv/ppk_ram.sv
sv/ppk_front.sv
sv/ppk_queue.sv
sv/ppk_back.sv
sv/palette_pixel_packer_12bpp_top.sv
test/palette_pixel_packer_12bpp_top_tb.sv
